FILE: rtl/core/p2dpc_pkg.sv
`timescale 1ns / 1ps

package p2dpc_pkg;

   // Stream widths
   localparam int REQ_TDATA_W = 200;
   localparam int RSP_TDATA_W = 128;

   // Double-precision datapath widths
   localparam int DBL_W  = 64;
   localparam int WIDE_W = 108;
   localparam int EXP_W  = 14;

   // Fixed double constants
   localparam logic [DBL_W-1:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
   localparam logic [DBL_W-1:0] DBL_NEG_666 = 64'hC084_D000_0000_0000;
   localparam logic [DBL_W-1:0] DBL_DEF_NAN = 64'hFFF8_0000_0000_0000;

   // Request kinds carried in tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CAL  = 1'b1;

   typedef enum logic {
      FOP_MUL,
      FOP_ADD
   } fpu_op_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SETUP,
      F_MUL,
      F_ADD,
      F_NORM,
      F_DENORM,
      F_ROUND,
      F_DONE
   } fpu_state_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SUM_INIT,
      S_PB_GO,
      S_PB_WAIT,
      S_PA_GO,
      S_PA_WAIT,
      S_RD,
      S_COEF,
      S_M1_GO,
      S_M1_WAIT,
      S_M2_GO,
      S_M2_WAIT,
      S_ADD_WAIT,
      S_NEXT,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic             start;
      fpu_op_type       op;
      logic [DBL_W-1:0] opa;
      logic [DBL_W-1:0] opb;
   } fpu_req_type;

   typedef struct packed {
      logic             done;
      logic [DBL_W-1:0] result;
   } fpu_rsp_type;

endpackage

FILE: rtl/core/p2dpc_ram.sv
`timescale 1ns / 1ps

module p2dpc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 100,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/p2dpc_fpu.sv
`timescale 1ns / 1ps

module p2dpc_fpu (
   input  logic                   clock,
   input  logic                   reset,
   input  p2dpc_pkg::fpu_req_type req,
   output p2dpc_pkg::fpu_rsp_type rsp
);

   localparam int WW = p2dpc_pkg::WIDE_W;
   localparam int EW = p2dpc_pkg::EXP_W;

   p2dpc_pkg::fpu_state_type state_ff, state_in;
   p2dpc_pkg::fpu_op_type    op_ff, op_in;
   logic [63:0]              a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic                     sign_ff, sign_in, zsign_ff, zsign_in, sub_ff, sub_in;
   logic signed [EW-1:0]     fexp_ff, fexp_in;
   logic [WW-1:0]            w_ff, w_in, w2_ff, w2_in;
   logic [1:0]               pp_ff, pp_in;

   always_comb begin
      logic [10:0]  ea, eb, eaa, ebb, ebig, esml, d;
      logic         nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
      logic [52:0]  ma, mb, mbig, msml;
      logic [WW-1:0] wsm, ones;
      logic [26:0]  opx, opy;
      logic [53:0]  prod, m2;
      logic [6:0]   sh;
      logic [EW-1:0] amt;
      logic signed [EW-1:0] fr;
      logic         up;

      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      sign_in  = sign_ff;
      zsign_in = zsign_ff;
      sub_in   = sub_ff;
      fexp_in  = fexp_ff;
      w_in     = w_ff;
      w2_in    = w2_ff;
      pp_in    = pp_ff;

      // Unpack operands
      ea     = a_ff[62:52];
      eb     = b_ff[62:52];
      nan_a  = (ea == 11'h7FF) && (a_ff[51:0] != '0);
      nan_b  = (eb == 11'h7FF) && (b_ff[51:0] != '0);
      inf_a  = (ea == 11'h7FF) && (a_ff[51:0] == '0);
      inf_b  = (eb == 11'h7FF) && (b_ff[51:0] == '0);
      zero_a = (a_ff[62:0] == '0);
      zero_b = (b_ff[62:0] == '0);
      eaa    = (ea == '0) ? 11'd1 : ea;
      ebb    = (eb == '0) ? 11'd1 : eb;
      ma     = {(ea != '0), a_ff[51:0]};
      mb     = {(eb != '0), b_ff[51:0]};
      swap   = (b_ff[62:0] > a_ff[62:0]);
      ebig   = swap ? ebb : eaa;
      esml   = swap ? eaa : ebb;
      mbig   = swap ? mb : ma;
      msml   = swap ? ma : mb;
      d      = ebig - esml;
      ones   = '1;
      wsm    = {1'b0, msml, 54'd0};

      // Partial product select
      case (pp_ff)
         2'd0: begin
            opx = ma[26:0];
            opy = mb[26:0];
            sh  = 7'd2;
         end
         2'd1: begin
            opx = ma[26:0];
            opy = {1'b0, mb[52:27]};
            sh  = 7'd29;
         end
         2'd2: begin
            opx = {1'b0, ma[52:27]};
            opy = mb[26:0];
            sh  = 7'd29;
         end
         default: begin
            opx = {1'b0, ma[52:27]};
            opy = {1'b0, mb[52:27]};
            sh  = 7'd56;
         end
      endcase
      prod = opx * opy;

      // Right shift amount for subnormal results
      amt = EW'(14'sd1 - fexp_ff);

      // Rounding to nearest even
      up = w_ff[54] && ((|w_ff[53:0]) || w_ff[55]);
      m2 = {1'b0, w_ff[107:55]} + 54'(up);
      fr = m2[53] ? (fexp_ff + 14'sd1) : fexp_ff;

      case (state_ff)
         p2dpc_pkg::F_IDLE: begin
            if (req.start) begin
               a_in     = req.opa;
               b_in     = req.opb;
               op_in    = req.op;
               state_in = p2dpc_pkg::F_SETUP;
            end
         end
         p2dpc_pkg::F_SETUP: begin
            state_in = p2dpc_pkg::F_DONE;
            if (nan_a) begin
               res_in = a_ff | 64'h0008_0000_0000_0000;
            end else if (nan_b) begin
               res_in = b_ff | 64'h0008_0000_0000_0000;
            end else if (op_ff == p2dpc_pkg::FOP_MUL) begin
               if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                  res_in = p2dpc_pkg::DBL_DEF_NAN;
               end else if (inf_a || inf_b) begin
                  res_in = {a_ff[63] ^ b_ff[63], 11'h7FF, 52'd0};
               end else if (zero_a || zero_b) begin
                  res_in = {a_ff[63] ^ b_ff[63], 63'd0};
               end else begin
                  sign_in  = a_ff[63] ^ b_ff[63];
                  zsign_in = a_ff[63] ^ b_ff[63];
                  fexp_in  = $signed({3'b000, eaa}) + $signed({3'b000, ebb}) - 14'sd1022;
                  w_in     = '0;
                  pp_in    = '0;
                  state_in = p2dpc_pkg::F_MUL;
               end
            end else begin
               if (inf_a && inf_b && (a_ff[63] != b_ff[63])) begin
                  res_in = p2dpc_pkg::DBL_DEF_NAN;
               end else if (inf_a) begin
                  res_in = a_ff;
               end else if (inf_b) begin
                  res_in = b_ff;
               end else begin
                  // Align the smaller operand, jam lost bits into the lsb
                  sign_in  = swap ? b_ff[63] : a_ff[63];
                  zsign_in = a_ff[63] & b_ff[63];
                  sub_in   = a_ff[63] ^ b_ff[63];
                  fexp_in  = $signed({3'b000, ebig}) + 14'sd1;
                  w_in     = {1'b0, mbig, 54'd0};
                  if (d >= 11'd108) begin
                     w2_in = {{(WW-1){1'b0}}, (wsm != '0)};
                  end else begin
                     w2_in = (wsm >> d) | {{(WW-1){1'b0}}, |(wsm & ~(ones << d))};
                  end
                  state_in = p2dpc_pkg::F_ADD;
               end
            end
         end
         p2dpc_pkg::F_MUL: begin
            w_in  = w_ff + (WW'(prod) << sh);
            pp_in = pp_ff + 2'd1;
            if (pp_ff == 2'd3) begin
               state_in = p2dpc_pkg::F_NORM;
            end
         end
         p2dpc_pkg::F_ADD: begin
            w_in     = sub_ff ? (w_ff - w2_ff) : (w_ff + w2_ff);
            state_in = p2dpc_pkg::F_NORM;
         end
         p2dpc_pkg::F_NORM: begin
            if (w_ff == '0) begin
               res_in   = {zsign_ff, 63'd0};
               state_in = p2dpc_pkg::F_DONE;
            end else if (fexp_ff < 14'sd1) begin
               state_in = p2dpc_pkg::F_DENORM;
            end else if (w_ff[WW-1] || (fexp_ff == 14'sd1)) begin
               state_in = p2dpc_pkg::F_ROUND;
            end else if ((w_ff[WW-1:WW-8] == '0) && (fexp_ff > 14'sd8)) begin
               w_in    = w_ff << 8;
               fexp_in = fexp_ff - 14'sd8;
            end else begin
               w_in    = w_ff << 1;
               fexp_in = fexp_ff - 14'sd1;
            end
         end
         p2dpc_pkg::F_DENORM: begin
            if (amt >= EW'(WW)) begin
               w_in = {{(WW-1){1'b0}}, (w_ff != '0)};
            end else begin
               w_in = (w_ff >> amt) | {{(WW-1){1'b0}}, |(w_ff & ~(ones << amt))};
            end
            fexp_in  = 14'sd1;
            state_in = p2dpc_pkg::F_ROUND;
         end
         p2dpc_pkg::F_ROUND: begin
            if (fr >= 14'sd2047) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else if (m2[53]) begin
               res_in = {sign_ff, fr[10:0], 52'd0};
            end else begin
               res_in = {sign_ff, (m2[52] ? fr[10:0] : 11'd0), m2[51:0]};
            end
            state_in = p2dpc_pkg::F_DONE;
         end
         p2dpc_pkg::F_DONE: begin
            state_in = p2dpc_pkg::F_IDLE;
         end
         default: begin
            state_in = p2dpc_pkg::F_IDLE;
         end
      endcase
   end

   // Hold the unit state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= p2dpc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold operands and the working mantissa
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      sign_ff  <= sign_in;
      zsign_ff <= zsign_in;
      sub_ff   <= sub_in;
      fexp_ff  <= fexp_in;
      w_ff     <= w_in;
      w2_ff    <= w2_in;
      pp_ff    <= pp_in;
   end

   assign rsp.done   = (state_ff == p2dpc_pkg::F_DONE);
   assign rsp.result = res_ff;

endmodule

FILE: rtl/core/poly2d_position_correction.sv
`timescale 1ns / 1ps
// Load beat: written into the table from idle, and ready stays high for the next beat.
// Calibrate beat: evaluated term by term, zero coefficients skipped, on the single shared
// double-precision multiply/add unit, with the powers of each input built up step by step.
// One beat at a time: ready stays low until the result is moved to the output register.
// Reset: synchronous; a clearing pass then zeroes all TABLE_SIZE (100) table entries.
module poly2d_position_correction #(
   parameter int FIT_ORDER = 4,
   parameter int ROUNDS    = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // coef_index[6:0], coef_bits[70:7], raw_x_bits[134:71], raw_y_bits[198:135]
   input  logic [p2dpc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cal_x_bits[63:0], cal_y_bits[127:64]
   output logic [p2dpc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // ok[0]
   output logic                               rsp_tuser
);

   localparam int ORD_N      = FIT_ORDER + 1;
   localparam int TERMS      = ORD_N * ORD_N;
   localparam int SETS       = 2 * ROUNDS;
   localparam int TABLE_SIZE = SETS * TERMS;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int K_W        = $clog2(ORD_N);
   localparam int SET_W      = $clog2(SETS);
   localparam logic [K_W-1:0]    K_LAST    = K_W'(FIT_ORDER);
   localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(SETS - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

   p2dpc_pkg::seq_state_type state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic              rsp_ok_ff, rsp_ok_in, ok_ff, ok_in;
   logic [63:0]       x_ff, x_in, y_ff, y_in, pa_ff, pa_in, acc_ff, acc_in;
   logic [63:0]       term_ff, term_in;
   logic [63:0]       pb_ff [0:FIT_ORDER];
   logic [63:0]       pb_in [0:FIT_ORDER];
   logic [K_W-1:0]    j_ff, j_in, k_ff, k_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic              pp_go_ff;

   p2dpc_pkg::fpu_req_type fpu_req;
   p2dpc_pkg::fpu_rsp_type fpu_rsp;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic [63:0]       ram_wdata, ram_rdata;

   always_comb begin
      logic [31:0] idx_ext;
      logic [63:0] raw_x, raw_y, a_val, b_val;
      logic        bad_x, bad_y;

      state_in     = state_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_ok_in    = rsp_ok_ff;
      ok_in        = ok_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      pa_in        = pa_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      pb_in        = pb_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      set_in       = set_ff;

      req_tready    = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = '0;
      fpu_req.start = 1'b0;
      fpu_req.op    = p2dpc_pkg::FOP_MUL;
      fpu_req.opa   = term_ff;
      fpu_req.opb   = pa_ff;

      idx_ext = 32'(req_tdata[6:0]);
      raw_x   = req_tdata[134:71];
      raw_y   = req_tdata[198:135];
      // Not positive: a zero of either sign, or a negative non-NaN
      bad_x   = (raw_x[62:0] == '0) ||
                (raw_x[63] && !((raw_x[62:52] == 11'h7FF) && (raw_x[51:0] != '0)));
      bad_y   = (raw_y[62:0] == '0) ||
                (raw_y[63] && !((raw_y[62:52] == 11'h7FF) && (raw_y[51:0] != '0)));
      a_val   = set_ff[0] ? y_ff : x_ff;
      b_val   = set_ff[0] ? x_ff : y_ff;

      case (state_ff)
         p2dpc_pkg::S_CLEAR: begin
            // Zero one table entry per cycle
            ram_we  = 1'b1;
            slot_in = slot_ff + SLOT_W'(1);
            if (slot_ff == SLOT_LAST) begin
               slot_in  = '0;
               state_in = p2dpc_pkg::S_IDLE;
            end
         end
         p2dpc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == p2dpc_pkg::CMD_LOAD) begin
                  if (idx_ext < 32'(TABLE_SIZE)) begin
                     ram_we    = 1'b1;
                     ram_waddr = idx_ext[SLOT_W-1:0];
                     ram_wdata = req_tdata[70:7];
                  end
               end else if (bad_x || bad_y) begin
                  ok_in    = 1'b0;
                  x_in     = p2dpc_pkg::DBL_NEG_666;
                  y_in     = p2dpc_pkg::DBL_NEG_666;
                  state_in = p2dpc_pkg::S_FINISH;
               end else begin
                  ok_in    = 1'b1;
                  x_in     = raw_x;
                  y_in     = raw_y;
                  set_in   = '0;
                  slot_in  = '0;
                  state_in = p2dpc_pkg::S_SUM_INIT;
               end
            end
         end
         p2dpc_pkg::S_SUM_INIT: begin
            pb_in[0] = p2dpc_pkg::DBL_ONE;
            pa_in    = p2dpc_pkg::DBL_ONE;
            acc_in   = '0;
            k_in     = K_W'(1);
            state_in = p2dpc_pkg::S_PB_GO;
         end
         p2dpc_pkg::S_PB_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.opa   = pb_ff[k_ff - K_W'(1)];
            fpu_req.opb   = b_val;
            state_in      = p2dpc_pkg::S_PB_WAIT;
         end
         p2dpc_pkg::S_PB_WAIT: begin
            if (fpu_rsp.done) begin
               pb_in[k_ff] = fpu_rsp.result;
               if (k_ff == K_LAST) begin
                  j_in     = '0;
                  k_in     = '0;
                  state_in = p2dpc_pkg::S_RD;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  state_in = p2dpc_pkg::S_PB_GO;
               end
            end
         end
         p2dpc_pkg::S_PA_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.opa   = pa_ff;
            fpu_req.opb   = a_val;
            state_in      = p2dpc_pkg::S_PA_WAIT;
         end
         p2dpc_pkg::S_PA_WAIT: begin
            if (fpu_rsp.done) begin
               pa_in    = fpu_rsp.result;
               k_in     = '0;
               state_in = p2dpc_pkg::S_RD;
            end
         end
         p2dpc_pkg::S_RD: begin
            state_in = p2dpc_pkg::S_COEF;
         end
         p2dpc_pkg::S_COEF: begin
            // Skip coefficients equal to zero
            term_in  = ram_rdata;
            state_in = (ram_rdata[62:0] == '0) ? p2dpc_pkg::S_NEXT : p2dpc_pkg::S_M1_GO;
         end
         p2dpc_pkg::S_M1_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.opa   = term_ff;
            fpu_req.opb   = pa_ff;
            state_in      = p2dpc_pkg::S_M1_WAIT;
         end
         p2dpc_pkg::S_M1_WAIT: begin
            if (fpu_rsp.done) begin
               term_in  = fpu_rsp.result;
               state_in = p2dpc_pkg::S_M2_GO;
            end
         end
         p2dpc_pkg::S_M2_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.opa   = term_ff;
            fpu_req.opb   = pb_ff[k_ff];
            state_in      = p2dpc_pkg::S_M2_WAIT;
         end
         p2dpc_pkg::S_M2_WAIT: begin
            if (fpu_rsp.done) begin
               // Start the accumulate as soon as the product lands
               term_in  = fpu_rsp.result;
               state_in = p2dpc_pkg::S_ADD_WAIT;
            end
         end
         p2dpc_pkg::S_ADD_WAIT: begin
            fpu_req.op    = p2dpc_pkg::FOP_ADD;
            fpu_req.opa   = acc_ff;
            fpu_req.opb   = term_ff;
            fpu_req.start = pp_go_ff;
            if (fpu_rsp.done) begin
               acc_in   = fpu_rsp.result;
               state_in = p2dpc_pkg::S_NEXT;
            end
         end
         p2dpc_pkg::S_NEXT: begin
            slot_in = slot_ff + SLOT_W'(1);
            if (k_ff == K_LAST) begin
               if (j_ff == K_LAST) begin
                  if (set_ff[0]) begin
                     y_in = acc_ff;
                  end else begin
                     x_in = acc_ff;
                  end
                  if (set_ff == SET_LAST) begin
                     state_in = p2dpc_pkg::S_FINISH;
                  end else begin
                     set_in   = set_ff + SET_W'(1);
                     state_in = p2dpc_pkg::S_SUM_INIT;
                  end
               end else begin
                  j_in     = j_ff + K_W'(1);
                  state_in = p2dpc_pkg::S_PA_GO;
               end
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = p2dpc_pkg::S_RD;
            end
         end
         p2dpc_pkg::S_FINISH: begin
            // Move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               state_in     = p2dpc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = p2dpc_pkg::S_IDLE;
         end
      endcase
   end

   // Issue the accumulate once, on entry to the add wait
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_go_ff <= 1'b0;
      end else begin
         pp_go_ff <= (state_ff == p2dpc_pkg::S_M2_WAIT) && fpu_rsp.done;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= p2dpc_pkg::S_CLEAR;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold working values
   always_ff @(posedge clock) begin
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_ok_ff <= rsp_ok_in;
      ok_ff     <= ok_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      pa_ff     <= pa_in;
      acc_ff    <= acc_in;
      term_ff   <= term_in;
      pb_ff     <= pb_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      set_ff    <= set_in;
   end

   p2dpc_ram #(
      .WIDTH(64),
      .DEPTH(TABLE_SIZE)
   ) u_coef_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(slot_ff),
      .rdata(ram_rdata)
   );

   p2dpc_fpu u_fpu (
      .clock(clock),
      .reset(reset),
      .req  (fpu_req),
      .rsp  (fpu_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_ok_ff;

endmodule

FILE: sim/tb_poly2d_position_correction.sv
`timescale 1ns / 1ps

module tb_poly2d_position_correction;

   localparam int ORDER      = 4;
   localparam int NROUNDS    = 2;
   localparam int NTERMS     = (ORDER + 1) * (ORDER + 1);
   localparam int NSLOTS     = NROUNDS * 2 * NTERMS;
   localparam int QUIET_MAX  = 50000;
   localparam int HOLD_LEN   = 4000;
   localparam int RAND_ITEMS = 1200;

   typedef struct packed {
      logic        ok;
      logic [63:0] cal_x;
      logic [63:0] cal_y;
   } position_type;

   // Predicts calibrated positions from a private copy of the coefficient table
   class position_scoreboard;
      logic [63:0]  coef_store [NSLOTS];
      position_type pending_positions [$];
      int           errors;

      function new();
         foreach (coef_store[i]) coef_store[i] = '0;
         errors = 0;
      endfunction

      // One polynomial sum over a coefficient set, primary a and secondary b
      function real poly_eval(int set_num, real a, real b);
         real pw_a [ORDER + 1];
         real pw_b [ORDER + 1];
         real acc;
         real c;
         pw_a[0] = 1.0;
         pw_b[0] = 1.0;
         for (int j = 1; j <= ORDER; j++) begin
            pw_a[j] = pw_a[j-1] * a;
            pw_b[j] = pw_b[j-1] * b;
         end
         acc = 0.0;
         for (int j = 0; j <= ORDER; j++) begin
            for (int k = 0; k <= ORDER; k++) begin
               c = $bitstoreal(coef_store[set_num * NTERMS + j * (ORDER + 1) + k]);
               if (c != 0.0) acc = acc + (c * pw_a[j]) * pw_b[k];
            end
         end
         return acc;
      endfunction

      // Note an accepted request beat
      function void note_request(logic cmd, logic [6:0] idx, logic [63:0] coef,
                                 logic [63:0] raw_x, logic [63:0] raw_y);
         position_type p;
         real x;
         real y;
         if (cmd == p2dpc_pkg::CMD_LOAD) begin
            if (idx < NSLOTS) coef_store[idx] = coef;
            return;
         end
         x = $bitstoreal(raw_x);
         y = $bitstoreal(raw_y);
         if (x <= 0.0 || y <= 0.0) begin
            p.ok    = 1'b0;
            p.cal_x = p2dpc_pkg::DBL_NEG_666;
            p.cal_y = p2dpc_pkg::DBL_NEG_666;
         end else begin
            for (int r = 0; r < NROUNDS; r++) begin
               x = poly_eval(2 * r, x, y);
               y = poly_eval(2 * r + 1, y, x);
            end
            p.ok    = 1'b1;
            p.cal_x = $realtobits(x);
            p.cal_y = $realtobits(y);
         end
         pending_positions.push_back(p);
      endfunction

      function bit is_nan(logic [63:0] v);
         return v[62:52] == 11'h7FF && v[51:0] != '0;
      endfunction

      // Any NaN payload is accepted where a NaN is predicted
      function bit same_double(logic [63:0] e, logic [63:0] a);
         return (e === a) || (is_nan(e) && is_nan(a));
      endfunction

      // Compare one accepted result beat with the oldest prediction
      function void check_position(logic ok, logic [63:0] cx, logic [63:0] cy);
         position_type p;
         if (pending_positions.size() == 0) begin
            $error("unexpected result: ok=%0b cal_x=%h cal_y=%h", ok, cx, cy);
            errors++;
            return;
         end
         p = pending_positions.pop_front();
         if (ok !== p.ok) begin
            $error("ok mismatch: expected %0b actual %0b", p.ok, ok);
            errors++;
         end
         if (!same_double(p.cal_x, cx)) begin
            $error("cal_x_bits mismatch: expected %h actual %h", p.cal_x, cx);
            errors++;
         end
         if (!same_double(p.cal_y, cy)) begin
            $error("cal_y_bits mismatch: expected %h actual %h", p.cal_y, cy);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [p2dpc_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [p2dpc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tuser;

   position_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   int  quiet_cycles;

   poly2d_position_correction dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request beat, with random idle cycles ahead of it
   task automatic send_beat(logic cmd, logic [6:0] idx, logic [63:0] coef,
                            logic [63:0] raw_x, logic [63:0] raw_y);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, raw_y, raw_x, coef, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, idx, coef, raw_x, raw_y);
   endtask

   task automatic load_coef(int idx, real value);
      send_beat(p2dpc_pkg::CMD_LOAD, idx[6:0], $realtobits(value), 64'($urandom),
                64'($urandom));
   endtask

   task automatic calibrate(real x, real y);
      send_beat(p2dpc_pkg::CMD_CAL, 7'($urandom), {$urandom, $urandom}, $realtobits(x),
                $realtobits(y));
   endtask

   // Wait until every predicted result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_positions.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Zero, random bits, or a small coefficient scaled down with total power so sums stay finite
   function automatic logic [63:0] random_coef(int idx);
      int  pick;
      real v;
      pick = $urandom_range(0, 99);
      if (pick < 40) return '0;
      if (pick < 45) return {$urandom, $urandom};
      v = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      if (idx % NTERMS == 5 || idx % NTERMS == 1) v = v + 1.0;
      for (int p = 0; p < (idx % NTERMS) / 5 + idx % 5; p++) v = v / 1000.0;
      return $realtobits(v);
   endfunction

   function automatic logic [63:0] random_raw();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $realtobits(($urandom_range(1, 1000000)) / 1000.0);
      if (pick < 90) return $realtobits(-(real'($urandom_range(0, 1000000)) / 1000.0));
      if (pick < 92) return 64'h0;
      if (pick < 93) return 64'h8000_0000_0000_0000;
      if (pick < 96) return {12'h7FF, 20'h8_0000 | 20'($urandom), $urandom};
      return {$urandom, $urandom};
   endfunction

   task automatic random_items(int count);
      int idx;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 75) begin
            idx = ($urandom_range(0, 99) < 5) ? $urandom_range(NSLOTS, 127)
                                                : $urandom_range(0, NSLOTS - 1);
            send_beat(p2dpc_pkg::CMD_LOAD, idx[6:0], random_coef(idx), {$urandom, $urandom},
                      {$urandom, $urandom});
         end else begin
            send_beat(p2dpc_pkg::CMD_CAL, 7'($urandom), {$urandom, $urandom}, random_raw(),
                      random_raw());
         end
      end
   endtask

   // Result side: random stalls, long hold-off on request
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_position(rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64]);
         if (hold_request) begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no accepted beat
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_poly2d_position_correction failed");
            $finish;
         end
      end
   end

   initial begin
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tuser      = p2dpc_pkg::CMD_LOAD;
      req_tdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, non-positive and NaN raw values
      calibrate(1.0, 1.0);
      calibrate(0.0, 5.0);
      send_beat(p2dpc_pkg::CMD_CAL, 7'h7F, '1, 64'h4000_0000_0000_0000,
                64'h8000_0000_0000_0000);
      calibrate(-3.0, 2.0);
      send_beat(p2dpc_pkg::CMD_CAL, 7'h00, '0, p2dpc_pkg::DBL_DEF_NAN,
                64'h4000_0000_0000_0000);
      // x passes through and y takes the new x in both rounds, plus an offset, edges of the table
      load_coef(5, 1.0);
      load_coef(NTERMS + 1, 1.0);
      load_coef(2 * NTERMS + 5, 1.0);
      load_coef(3 * NTERMS + 1, 1.0);
      load_coef(0, 0.5);
      load_coef(NSLOTS - 1, 1.0e-12);
      send_beat(p2dpc_pkg::CMD_LOAD, 7'd100, $realtobits(7.0), '1, '1);
      send_beat(p2dpc_pkg::CMD_LOAD, 7'h7F, '1, '0, '0);
      calibrate(123.25, 456.5);
      send_beat(p2dpc_pkg::CMD_CAL, 7'h00, '0, 64'h7FEF_FFFF_FFFF_FFFF,
                64'h0000_0000_0000_0001);
      // Negative zero coefficient is skipped, NaN coefficient propagates
      send_beat(p2dpc_pkg::CMD_LOAD, 7'd6, 64'h8000_0000_0000_0000, '0, '0);
      calibrate(10.0, 20.0);
      send_beat(p2dpc_pkg::CMD_LOAD, 7'd7, '1, '0, '0);
      calibrate(10.0, 20.0);
      send_beat(p2dpc_pkg::CMD_LOAD, 7'd7, 64'h0, '0, '0);
      calibrate(1000.0, 0.001);
      drain();

      // Fill the result path while the receiver holds off
      hold_request = 1'b1;
      for (int n = 0; n < 6; n++) calibrate(n + 1.5, 2.0 * n + 1.0);
      drain();

      send_idle_pct = 0;  recv_stall_pct = 0;
      random_items(RAND_ITEMS / 4);
      drain();
      send_idle_pct = 67; recv_stall_pct = 0;
      random_items(RAND_ITEMS / 4);
      drain();
      send_idle_pct = 0;  recv_stall_pct = 67;
      random_items(RAND_ITEMS / 4);
      drain();
      send_idle_pct = 16; recv_stall_pct = 16;
      random_items(RAND_ITEMS / 4);
      drain();

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_positions.size() == 0) begin
         $display("tb_poly2d_position_correction passed");
      end else begin
         $display("tb_poly2d_position_correction failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/p2dpc_pkg.sv
rtl/core/p2dpc_ram.sv
rtl/core/p2dpc_fpu.sv
rtl/core/poly2d_position_correction.sv
sim/tb_poly2d_position_correction.sv
